// ===== design/vtr_pkg.sv =====
// Shared constants and types for the virtual trackball rotation block.
`timescale 1ns / 1ps
package vtr_pkg;

    localparam int VTR_COORD_FRAC_BITS = 14;
    localparam int VTR_CURSOR_BITS     = 12;
    localparam int WIN_BITS            = 13;
    localparam int OUT_BITS            = 16;

    localparam logic [WIN_BITS-1:0] WIN_RESET = 13'd1024;

    localparam logic [1:0] ACT_PRESS  = 2'd0;
    localparam logic [1:0] ACT_OTHER  = 2'd1;
    localparam logic [1:0] ACT_MOTION = 2'd2;
    localparam logic [1:0] ACT_SPARE  = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Status of a bit-serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== design/vtr_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vtr_div #(
    parameter int NW = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NW-1:0]     i_num,
    input  logic [NW-1:0]     i_den,
    output logic [NW-1:0]     o_quo,
    output vtr_pkg::t_unit_sts o_sts
);
    import vtr_pkg::*;

    localparam int CNTW = $clog2(NW + 1);

    logic [NW:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [NW-1:0] r_den;
    logic [CNTW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   n_trial;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem[NW-1:0], r_q[NW-1]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNTW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
                r_q   <= {r_q[NW-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_q;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

endmodule

// ===== design/vtr_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module vtr_sqrt #(
    parameter int SW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SW-1:0]       i_rad,
    output logic [SW/2-1:0]     o_root,
    output vtr_pkg::t_unit_sts  o_sts
);
    import vtr_pkg::*;

    localparam int HW   = SW / 2;
    localparam int RW   = HW + 3;
    localparam int CNTW = $clog2(HW + 1);

    logic [SW-1:0]   r_rad;
    logic [RW-1:0]   r_rem;
    logic [HW-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [RW-1:0]   n_t;
    logic [RW-1:0]   n_trial;
    logic            n_ge;

    always_comb begin
        n_t     = {r_rem[RW-3:0], r_rad[SW-1:SW-2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = (n_t >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(HW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[SW-3:0], 2'b00};
                r_rem  <= n_ge ? (n_t - n_trial) : n_t;
                r_root <= {r_root[HW-2:0], n_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root     = r_root;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== design/virtual_trackball_rotation.sv =====
// Top level of the virtual trackball rotation block: sequencer and data path.
`timescale 1ns / 1ps
// Usage: pointer events enter as words on the input channel (i_in_valid,
// o_in_stall) with an action code and cursor position. Every accepted word
// yields exactly one result word on the output channel (o_out_valid,
// i_out_stall). A left press projects the cursor onto the trackball sphere,
// stores the vector and starts tracking; any other button event stops it.
// A tracked motion whose vector changed returns an angle and an unnormalized
// axis with o_rotate_valid set; otherwise the result word carries zeros.
// Window size is written through the plain write port (index 0 width,
// index 1 height); the user must write it only while the block is idle,
// and the block itself leaves this unchecked. Button events other than a
// press, and motion while not tracking, go straight to the result. A press
// or a tracked motion runs five serial divisions and two serial roots; a
// rotation adds a third root for the chord. The input is stalled while an
// item is in work and opens as its result is loaded. A stalled result
// holds in the output register while the next item is worked on; that
// item then waits for the register. Reset clears tracking, the stored
// vector and both channels, and sets both window sizes to 1024.
module virtual_trackball_rotation #(
    parameter int COORD_FRAC_BITS = vtr_pkg::VTR_COORD_FRAC_BITS,
    parameter int CURSOR_BITS     = vtr_pkg::VTR_CURSOR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [vtr_pkg::WIN_BITS-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [CURSOR_BITS-1:0]       i_cursor_x,
    input  logic [CURSOR_BITS-1:0]       i_cursor_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_rotate_valid,
    output logic [vtr_pkg::OUT_BITS-1:0] o_rotation_angle,
    output logic [vtr_pkg::OUT_BITS-1:0] o_axis_x,
    output logic [vtr_pkg::OUT_BITS-1:0] o_axis_y,
    output logic [vtr_pkg::OUT_BITS-1:0] o_axis_z
);
    import vtr_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int CW  = F + 3;                 // vector component width, signed
    localparam int MB  = (CURSOR_BITS + 1 > WIN_BITS) ? CURSOR_BITS + 1 : WIN_BITS;
    localparam int DB  = MB + 2;                // signed cursor offset width
    localparam int NWA = F + MB + 2;
    localparam int NWB = 2 * F + 3;
    localparam int NW  = (NWA > NWB) ? NWA : NWB;
    localparam int SW  = 2 * F + 4;             // square root radicand width
    localparam int RTW = SW / 2;
    localparam int PW  = 2 * CW;
    localparam int AW  = F + 18;                // angle product width

    localparam logic [63:0] ONE2_64 = 64'd1 << (2 * F);
    localparam logic [63:0] K_64    = ONE2_64 + (ONE2_64 + 64'd500) / 64'd1000;
    localparam logic [SW-1:0] ONE2  = SW'(ONE2_64);
    localparam logic [SW-1:0] KV    = SW'(K_64);
    localparam logic [NW-1:0] LIM_C = NW'(64'd1 << (F + 1));
    localparam logic [NW-1:0] LIM_N = NW'(64'd1 << F);
    localparam logic [PW-1:0] ONE_P = PW'(64'd1 << F);
    localparam logic [PW-1:0] HALF_P = PW'(64'd1 << (F - 1));
    localparam logic [AW-1:0] ANG_K = AW'(23040);
    localparam logic [AW-1:0] ANG_R = AW'(64'd1 << (F - 1));
    localparam logic [AW-1:0] ANG_MAX = AW'(46080);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_CDIV   = 20'h00002,
        S_CWAIT  = 20'h00004,
        S_SQ     = 20'h00008,
        S_ZSQ    = 20'h00010,
        S_ZWAIT  = 20'h00020,
        S_ZZ     = 20'h00040,
        S_LSQ    = 20'h00080,
        S_LWAIT  = 20'h00100,
        S_NDIV   = 20'h00200,
        S_NWAIT  = 20'h00400,
        S_DIFF   = 20'h00800,
        S_CHSQ   = 20'h01000,
        S_CHSQRT = 20'h02000,
        S_CHWAIT = 20'h04000,
        S_ANG    = 20'h08000,
        S_X1     = 20'h10000,
        S_X2     = 20'h20000,
        S_X3     = 20'h40000,
        S_DONE   = 20'h80000
    } t_state;

    t_state r_state;

    logic [WIN_BITS-1:0]    r_win_w;
    logic [WIN_BITS-1:0]    r_win_h;
    logic                   r_tracking;
    logic [1:0]             r_act;
    logic [CURSOR_BITS-1:0] r_x;
    logic [CURSOR_BITS-1:0] r_y;
    logic [1:0]             r_i;
    logic                   r_neg;
    logic signed [CW-1:0]   r_v    [0:2];
    logic signed [CW-1:0]   r_cur  [0:2];
    logic signed [CW-1:0]   r_last [0:2];
    logic signed [CW-1:0]   r_d    [0:2];
    logic [RTW-1:0]         r_len;
    logic [RTW-1:0]         r_chord;
    logic [SW-1:0]          r_acc;
    logic signed [PW-1:0]   r_x_acc;
    logic [AW-1:0]          r_angw;
    logic                   r_res_valid;
    logic [OUT_BITS-1:0]    r_res_ang;
    logic [OUT_BITS-1:0]    r_res_axis [0:2];

    logic                   r_div_start;
    logic [NW-1:0]          r_div_num;
    logic [NW-1:0]          r_div_den;
    logic                   r_sq_start;
    logic [SW-1:0]          r_sq_rad;

    logic                   r_ov;
    logic                   r_o_rot;
    logic [OUT_BITS-1:0]    r_o_ang;
    logic [OUT_BITS-1:0]    r_o_ax;
    logic [OUT_BITS-1:0]    r_o_ay;
    logic [OUT_BITS-1:0]    r_o_az;

    logic [NW-1:0]          div_quo;
    t_unit_sts              div_sts;
    logic [RTW-1:0]         sq_root;
    t_unit_sts              sq_sts;

    logic [WIN_BITS-1:0]    n_w;
    logic [WIN_BITS-1:0]    n_h;
    logic signed [DB-1:0]   n_cdiff;
    logic [DB-1:0]          n_cmag;
    logic [WIN_BITS-1:0]    n_cden;
    logic [CW-1:0]          n_vmag;
    logic signed [CW-1:0]   n_sq_op;
    logic signed [PW-1:0]   n_sq;
    logic signed [CW-1:0]   n_ma;
    logic signed [CW-1:0]   n_mb;
    logic signed [PW-1:0]   n_prod;
    logic [1:0]             n_j1;
    logic [1:0]             n_j2;
    logic signed [CW-1:0]   n_diff [0:2];
    logic                   n_diff_zero;
    logic [PW-1:0]          n_xmag;
    logic [PW-1:0]          n_xq;
    logic signed [CW-1:0]   n_xval;
    logic [AW-1:0]          n_ang_sh;
    logic [OUT_BITS-1:0]    n_ang16;
    logic                   n_out_free;

    // Saturate an unsigned quotient magnitude and apply the sign.
    function automatic logic signed [CW-1:0] f_sat(input logic [NW-1:0] q,
                                                   input logic neg,
                                                   input logic [NW-1:0] lim_n,
                                                   input logic [NW-1:0] lim_p);
        logic [NW-1:0] m;
        logic [CW-1:0] mc;
        if (neg) begin
            m = (q > lim_n) ? lim_n : q;
        end else begin
            m = (q > lim_p) ? lim_p : q;
        end
        mc = CW'(m);
        return neg ? -$signed(mc) : $signed(mc);
    endfunction

    vtr_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_quo   (div_quo),
        .o_sts   (div_sts)
    );

    vtr_sqrt #(.SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_rad   (r_sq_rad),
        .o_root  (sq_root),
        .o_sts   (sq_sts)
    );

    always_comb begin
        // A zero window size behaves as one pixel.
        n_w = (r_win_w == '0) ? WIN_BITS'(1) : r_win_w;
        n_h = (r_win_h == '0) ? WIN_BITS'(1) : r_win_h;

        // Offset from the window center, doubled: 2x - W for x, H - 2y for y.
        if (r_i == 2'd0) begin
            n_cdiff = $signed({{(DB-CURSOR_BITS-1){1'b0}}, r_x, 1'b0})
                    - $signed({{(DB-WIN_BITS){1'b0}}, n_w});
            n_cden  = n_w;
        end else begin
            n_cdiff = $signed({{(DB-WIN_BITS){1'b0}}, n_h})
                    - $signed({{(DB-CURSOR_BITS-1){1'b0}}, r_y, 1'b0});
            n_cden  = n_h;
        end
        n_cmag = n_cdiff[DB-1] ? DB'(-n_cdiff) : DB'(n_cdiff);
        n_vmag = r_v[r_i][CW-1] ? CW'(-r_v[r_i]) : CW'(r_v[r_i]);

        // One shared squarer for the sphere and chord sums.
        case (r_state)
            S_CHSQ:  n_sq_op = r_d[r_i];
            S_ZZ:    n_sq_op = r_v[2];
            default: n_sq_op = r_v[r_i];
        endcase
        n_sq = PW'(n_sq_op) * PW'(n_sq_op);

        // Cross product terms: last[j1]*cur[j2] - last[j2]*cur[j1].
        case (r_i)
            2'd0:    begin n_j1 = 2'd1; n_j2 = 2'd2; end
            2'd1:    begin n_j1 = 2'd2; n_j2 = 2'd0; end
            default: begin n_j1 = 2'd0; n_j2 = 2'd1; end
        endcase
        if (r_state == S_X1) begin
            n_ma = r_last[n_j1];
            n_mb = r_cur[n_j2];
        end else begin
            n_ma = r_last[n_j2];
            n_mb = r_cur[n_j1];
        end
        n_prod = PW'(n_ma) * PW'(n_mb);

        for (int k = 0; k < 3; k++) begin
            n_diff[k] = r_cur[k] - r_last[k];
        end
        n_diff_zero = (n_diff[0] == '0) && (n_diff[1] == '0) && (n_diff[2] == '0);

        // Round the cross term by 2^F, ties away from zero, and clamp to one.
        n_xmag = r_x_acc[PW-1] ? PW'(-r_x_acc) : PW'(r_x_acc);
        n_xq   = (n_xmag + HALF_P) >> F;
        if (n_xq > ONE_P) begin
            n_xq = ONE_P;
        end
        n_xval = r_x_acc[PW-1] ? -$signed(CW'(n_xq)) : $signed(CW'(n_xq));

        n_ang_sh = r_angw >> F;
        n_ang16  = (n_ang_sh > ANG_MAX) ? OUT_BITS'(ANG_MAX) : OUT_BITS'(n_ang_sh);

        n_out_free = !r_ov || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_w     <= WIN_RESET;
            r_win_h     <= WIN_RESET;
            r_tracking  <= 1'b0;
            r_ov        <= 1'b0;
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;
            r_i         <= '0;
            for (int k = 0; k < 3; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            r_sq_start  <= 1'b0;

            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_win_w <= i_cfg_data;
                end else begin
                    r_win_h <= i_cfg_data;
                end
            end

            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act       <= i_action;
                        r_x         <= i_cursor_x;
                        r_y         <= i_cursor_y;
                        r_i         <= '0;
                        r_res_valid <= 1'b0;
                        r_res_ang   <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_res_axis[k] <= '0;
                        end
                        if (i_action == ACT_PRESS) begin
                            r_state <= S_CDIV;
                        end else if (i_action == ACT_MOTION) begin
                            r_state <= r_tracking ? S_CDIV : S_DONE;
                        end else begin
                            // Other button events and the unused code stop tracking.
                            r_tracking <= 1'b0;
                            r_state    <= S_DONE;
                        end
                    end
                end
                S_CDIV: begin
                    r_neg       <= n_cdiff[DB-1];
                    r_div_num   <= (NW'(n_cmag) << (F + 1)) + NW'(n_cden);
                    r_div_den   <= NW'(n_cden) << 1;
                    r_div_start <= 1'b1;
                    r_state     <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (div_sts.done) begin
                        r_v[r_i] <= f_sat(div_quo, r_neg, LIM_C, LIM_C - 1'b1);
                        if (r_i == 2'd1) begin
                            r_i     <= '0;
                            r_state <= S_SQ;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_CDIV;
                        end
                    end
                end
                S_SQ: begin
                    r_acc <= ((r_i == 2'd0) ? '0 : r_acc) + SW'($unsigned(n_sq));
                    if (r_i == 2'd1) begin
                        r_i     <= '0;
                        r_state <= S_ZSQ;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_ZSQ: begin
                    r_sq_rad   <= KV - ((r_acc > ONE2) ? ONE2 : r_acc);
                    r_sq_start <= 1'b1;
                    r_state    <= S_ZWAIT;
                end
                S_ZWAIT: begin
                    if (sq_sts.done) begin
                        r_v[2]  <= $signed(CW'(sq_root));
                        r_state <= S_ZZ;
                    end
                end
                S_ZZ: begin
                    r_acc   <= r_acc + SW'($unsigned(n_sq));
                    r_state <= S_LSQ;
                end
                S_LSQ: begin
                    r_sq_rad   <= r_acc;
                    r_sq_start <= 1'b1;
                    r_state    <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (sq_sts.done) begin
                        r_len   <= sq_root;
                        r_i     <= '0;
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    r_neg       <= r_v[r_i][CW-1];
                    r_div_num   <= (NW'(n_vmag) << (F + 1)) + NW'(r_len);
                    r_div_den   <= NW'(r_len) << 1;
                    r_div_start <= 1'b1;
                    r_state     <= S_NWAIT;
                end
                S_NWAIT: begin
                    if (div_sts.done) begin
                        r_cur[r_i] <= f_sat(div_quo, r_neg, LIM_N, LIM_N);
                        if (r_act == ACT_PRESS) begin
                            r_last[r_i] <= f_sat(div_quo, r_neg, LIM_N, LIM_N);
                        end
                        if (r_i == 2'd2) begin
                            r_i <= '0;
                            if (r_act == ACT_PRESS) begin
                                r_tracking <= 1'b1;
                                r_state    <= S_DONE;
                            end else begin
                                r_state <= S_DIFF;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_d[k] <= n_diff[k];
                    end
                    r_i     <= '0;
                    r_state <= n_diff_zero ? S_DONE : S_CHSQ;
                end
                S_CHSQ: begin
                    r_acc <= ((r_i == 2'd0) ? '0 : r_acc) + SW'($unsigned(n_sq));
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= S_CHSQRT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_CHSQRT: begin
                    r_sq_rad   <= r_acc;
                    r_sq_start <= 1'b1;
                    r_state    <= S_CHWAIT;
                end
                S_CHWAIT: begin
                    if (sq_sts.done) begin
                        r_chord <= sq_root;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_angw  <= AW'(r_chord) * ANG_K + ANG_R;
                    r_i     <= '0;
                    r_state <= S_X1;
                end
                S_X1: begin
                    r_x_acc <= n_prod;
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_x_acc <= r_x_acc - n_prod;
                    r_state <= S_X3;
                end
                S_X3: begin
                    r_res_axis[r_i] <= OUT_BITS'(64'(n_xval));
                    if (r_i == 2'd2) begin
                        r_res_valid <= 1'b1;
                        r_res_ang   <= n_ang16;
                        for (int k = 0; k < 3; k++) begin
                            r_last[k] <= r_cur[k];
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_X1;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_ov    <= 1'b1;
                        r_o_rot <= r_res_valid;
                        r_o_ang <= r_res_ang;
                        r_o_ax  <= r_res_axis[0];
                        r_o_ay  <= r_res_axis[1];
                        r_o_az  <= r_res_axis[2];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_rotate_valid   = r_o_rot;
    assign o_rotation_angle = r_o_ang;
    assign o_axis_x         = r_o_ax;
    assign o_axis_y         = r_o_ay;
    assign o_axis_z         = r_o_az;

endmodule
